FILE: hw/rtl/pfde_pkg.sv
package pfde_pkg;

    localparam int PANEL_WIDTH  = 100;
    localparam int PANEL_HEIGHT = 64;
    localparam int NUM_PAGES    = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * NUM_PAGES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int PAGE_W       = $clog2(NUM_PAGES + 1);

    localparam logic [7:0] FIRST_CODE  = 8'h20;
    localparam int         GLYPH_W     = 'h06;
    localparam int         GLYPH_H     = 'h08;
    localparam int         GLYPH_COUNT = 'h10 * 'h06;
    localparam int         FONT_BYTES  = GLYPH_COUNT * GLYPH_W;
    localparam int         FONT_AW     = $clog2(FONT_BYTES);

    typedef enum logic [3:0] {
        CMD_SET        = 4'd0,
        CMD_CLEAR      = 4'd1,
        CMD_HRUN       = 4'd2,
        CMD_VRUN       = 4'd3,
        CMD_LINE       = 4'd4,
        CMD_GLYPH      = 4'd5,
        CMD_ERASE_PAGE = 4'd6,
        CMD_ERASE_ALL  = 4'd7,
        CMD_READ       = 4'd8
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_RD_REQ,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    // Byte address of a column within a page.
    function automatic logic [ADDR_W-1:0] page_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [7:0] col);
        logic [ADDR_W-1:0] w;
        w = ADDR_W'(PANEL_WIDTH);
        return ADDR_W'(page) * w + ADDR_W'(col);
    endfunction

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h06,8'h5F,8'h06,8'h00,8'h00,
        8'h07,8'h03,8'h00,8'h07,8'h03,8'h00,8'h24,8'h7E,8'h24,8'h7E,8'h24,8'h00,
        8'h24,8'h2B,8'h6A,8'h12,8'h00,8'h00,8'h63,8'h13,8'h08,8'h64,8'h63,8'h00,
        8'h30,8'h4C,8'h52,8'h22,8'h50,8'h00,8'h00,8'h07,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h3E,8'h41,8'h00,8'h00,8'h00,8'h00,8'h41,8'h3E,8'h00,8'h00,8'h00,
        8'h08,8'h3E,8'h1C,8'h3E,8'h08,8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00,
        8'h80,8'h60,8'h60,8'h00,8'h00,8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,
        8'h00,8'h60,8'h60,8'h00,8'h00,8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,8'h00,
        8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00,
        8'h62,8'h51,8'h49,8'h49,8'h46,8'h00,8'h22,8'h49,8'h49,8'h49,8'h36,8'h00,
        8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00,8'h2F,8'h49,8'h49,8'h49,8'h31,8'h00,
        8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00,8'h01,8'h71,8'h09,8'h05,8'h03,8'h00,
        8'h36,8'h49,8'h49,8'h49,8'h36,8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00,
        8'h00,8'h6C,8'h6C,8'h00,8'h00,8'h00,8'h00,8'hEC,8'h6C,8'h00,8'h00,8'h00,
        8'h08,8'h14,8'h22,8'h41,8'h00,8'h00,8'h24,8'h24,8'h24,8'h24,8'h24,8'h00,
        8'h00,8'h41,8'h22,8'h14,8'h08,8'h00,8'h02,8'h01,8'h59,8'h09,8'h06,8'h00,
        8'h3E,8'h41,8'h5D,8'h55,8'h1E,8'h00,8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00,
        8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00,
        8'h7F,8'h41,8'h41,8'h41,8'h3E,8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00,
        8'h7F,8'h09,8'h09,8'h09,8'h01,8'h00,8'h3E,8'h41,8'h49,8'h49,8'h7A,8'h00,
        8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00,
        8'h30,8'h40,8'h40,8'h40,8'h3F,8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00,
        8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00,8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h00,
        8'h7F,8'h02,8'h04,8'h08,8'h7F,8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00,
        8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00,
        8'h7F,8'h09,8'h09,8'h19,8'h66,8'h00,8'h26,8'h49,8'h49,8'h49,8'h32,8'h00,
        8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00,
        8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00,8'h3F,8'h40,8'h3C,8'h40,8'h3F,8'h00,
        8'h63,8'h14,8'h08,8'h14,8'h63,8'h00,8'h07,8'h08,8'h70,8'h08,8'h07,8'h00,
        8'h71,8'h49,8'h45,8'h43,8'h00,8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00,8'h00,
        8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,8'h00,8'h41,8'h41,8'h7F,8'h00,8'h00,
        8'h04,8'h02,8'h01,8'h02,8'h04,8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00,
        8'h00,8'h02,8'h05,8'h02,8'h00,8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,8'h00,
        8'h7F,8'h44,8'h44,8'h44,8'h38,8'h00,8'h38,8'h44,8'h44,8'h44,8'h28,8'h00,
        8'h38,8'h44,8'h44,8'h44,8'h7F,8'h00,8'h38,8'h54,8'h54,8'h54,8'h08,8'h00,
        8'h08,8'h7E,8'h09,8'h09,8'h00,8'h00,8'h18,8'h24,8'hA4,8'hA4,8'hFC,8'h00,
        8'h7F,8'h04,8'h04,8'h78,8'h00,8'h00,8'h00,8'h00,8'h7D,8'h40,8'h00,8'h00,
        8'h40,8'h80,8'h84,8'h7D,8'h00,8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,8'h00,
        8'h00,8'h00,8'h7F,8'h40,8'h00,8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00,
        8'h7C,8'h04,8'h04,8'h78,8'h00,8'h00,8'h38,8'h44,8'h44,8'h44,8'h38,8'h00,
        8'hFC,8'h44,8'h44,8'h44,8'h38,8'h00,8'h38,8'h44,8'h44,8'h44,8'hFC,8'h00,
        8'h44,8'h78,8'h44,8'h04,8'h08,8'h00,8'h08,8'h54,8'h54,8'h54,8'h20,8'h00,
        8'h04,8'h3E,8'h44,8'h24,8'h00,8'h00,8'h3C,8'h40,8'h20,8'h7C,8'h00,8'h00,
        8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00,8'h3C,8'h60,8'h30,8'h60,8'h3C,8'h00,
        8'h6C,8'h10,8'h10,8'h6C,8'h00,8'h00,8'h9C,8'hA0,8'h60,8'h3C,8'h00,8'h00,
        8'h64,8'h54,8'h54,8'h4C,8'h00,8'h00,8'h08,8'h3E,8'h41,8'h41,8'h00,8'h00,
        8'h00,8'h00,8'h77,8'h00,8'h00,8'h00,8'h00,8'h41,8'h41,8'h3E,8'h08,8'h00,
        8'h02,8'h01,8'h02,8'h01,8'h00,8'h00,8'h10,8'h20,8'h40,8'h38,8'h07,8'h00
    };

endpackage

FILE: hw/rtl/page_framebuffer_draw_engine_core.sv
// Page-mode monochrome framebuffer with a drawing engine. The store is one
// single-port RAM of PANEL_WIDTH bytes per 8-row page, and every drawn pixel is
// a read-modify-write of its byte (states ST_PIX_RD then ST_PIX_WR). Pixels
// outside the panel are skipped with no write. Erase page writes one byte a
// cycle across its page, and erase all sweeps the whole store the same way.
// After reset the same sweep clears the whole store (800 bytes with the default
// panel) before the first request is accepted. One request is worked on at a
// time; a new one is accepted while the previous result still waits on the
// output register.
module page_framebuffer_draw_engine_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_cmd,
    input  logic [7:0] s_x_first,
    input  logic [7:0] s_y_first,
    input  logic [7:0] s_x_second,
    input  logic [7:0] s_y_second,
    input  logic [7:0] s_glyph_code,
    input  logic       s_normal_ink,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_ignored
);

    localparam logic [pfde_pkg::ADDR_W-1:0] LAST_ADDR =
        pfde_pkg::ADDR_W'(pfde_pkg::STORE_BYTES - 1);

    // Frame store and its registered read port.
    logic [7:0] mem [pfde_pkg::STORE_BYTES];
    logic [pfde_pkg::ADDR_W-1:0] mem_addr;
    logic                        mem_we;
    logic [7:0]                  mem_wdata;
    logic [7:0]                  mem_q_reg;
    logic [7:0]                  font_q_reg;
    logic [pfde_pkg::FONT_AW-1:0] font_idx;

    pfde_pkg::state_t state_reg, state_next;
    pfde_pkg::cmd_t   cmd_reg, cmd_next, s_cmd_e;

    logic [7:0] x0_reg, x0_next, y0_reg, y0_next, xe_reg, xe_next, ye_reg, ye_next;
    logic [8:0] px_reg, px_next, py_reg, py_next;
    logic [7:0] ox_reg, ox_next, oy_reg, oy_next, rx_reg, rx_next, ry_reg, ry_next;
    logic [7:0] dx_reg, dx_next, dy_reg, dy_next, n_reg, n_next, i_reg, i_next;
    logic       xneg_reg, xneg_next, yneg_reg, yneg_next, inv_reg, inv_next;
    logic [6:0] item_reg, item_next;
    logic [2:0] gc_reg, gc_next, gr_reg, gr_next;
    logic [pfde_pkg::ADDR_W-1:0] fill_reg, fill_next, fend_reg, fend_next;
    logic       report_reg, report_next;
    logic [7:0] rd_reg, rd_next;
    logic       ign_reg, ign_next;
    logic       m_valid_reg, m_valid_next, m_ign_reg, m_ign_next;
    logic [7:0] m_rd_reg, m_rd_next;

    logic accept, out_free, in_panel, advance, adv_last, pix_on;
    logic [7:0] s_dx, s_dy, s_n, s_item;
    logic       s_xneg, s_yneg, s_page_ok;
    logic [8:0] sum_x, sum_y;
    logic [7:0] ox_adv, oy_adv, rx_adv, ry_adv;
    logic [2:0] gc_adv, gr_adv;
    logic [8:0] px_adv, py_adv;
    logic [pfde_pkg::ADDR_W-1:0] pix_addr, page_base;
    logic [7:0] bit_mask;

    assign s_cmd_e  = pfde_pkg::cmd_t'(s_cmd);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Decode of a new request.
    assign s_xneg    = s_x_second < s_x_first;
    assign s_yneg    = s_y_second < s_y_first;
    assign s_dx      = s_xneg ? s_x_first - s_x_second : s_x_second - s_x_first;
    assign s_dy      = s_yneg ? s_y_first - s_y_second : s_y_second - s_y_first;
    assign s_n       = (s_dx > s_dy) ? s_dx : s_dy;
    assign s_item    = s_glyph_code - pfde_pkg::FIRST_CODE;
    assign s_page_ok = s_y_first < 8'(pfde_pkg::NUM_PAGES);
    assign page_base = pfde_pkg::page_addr(s_y_first[pfde_pkg::PAGE_W-1:0], 8'd0);

    // Current pixel.
    assign in_panel = (px_reg < 9'(pfde_pkg::PANEL_WIDTH)) &&
                      (py_reg < 9'(pfde_pkg::PANEL_HEIGHT));
    assign pix_addr = pfde_pkg::page_addr(py_reg[3 +: pfde_pkg::PAGE_W], px_reg[7:0]);
    assign bit_mask = 8'd1 << py_reg[2:0];
    assign font_idx = pfde_pkg::FONT_AW'({item_reg, 2'b00}) +
                      pfde_pkg::FONT_AW'({item_reg, 1'b0}) + pfde_pkg::FONT_AW'(gc_reg);
    assign advance  = (state_reg == pfde_pkg::ST_PIX_WR) ||
                      ((state_reg == pfde_pkg::ST_PIX_RD) && !in_panel);

    // Ink of the current pixel.
    always_comb begin
        case (cmd_reg)
            pfde_pkg::CMD_CLEAR: pix_on = 1'b0;
            pfde_pkg::CMD_GLYPH: pix_on = font_q_reg[gr_reg] ^ inv_reg;
            default:             pix_on = 1'b1;
        endcase
    end

    // Line stepping keeps i*d = o*n + r; since d <= n a single subtraction
    // brings the remainder back below n.
    assign sum_x  = {1'b0, rx_reg} + {1'b0, dx_reg};
    assign sum_y  = {1'b0, ry_reg} + {1'b0, dy_reg};
    assign rx_adv = (sum_x >= {1'b0, n_reg}) ? 8'(sum_x - {1'b0, n_reg}) : sum_x[7:0];
    assign ox_adv = (sum_x >= {1'b0, n_reg}) ? ox_reg + 8'd1 : ox_reg;
    assign ry_adv = (sum_y >= {1'b0, n_reg}) ? 8'(sum_y - {1'b0, n_reg}) : sum_y[7:0];
    assign oy_adv = (sum_y >= {1'b0, n_reg}) ? oy_reg + 8'd1 : oy_reg;
    assign gr_adv = gr_reg + 3'd1;
    assign gc_adv = (gr_reg == 3'(pfde_pkg::GLYPH_H - 1)) ? gc_reg + 3'd1 : gc_reg;

    // Next pixel of the walk and whether the current one is the last.
    always_comb begin
        px_adv   = px_reg;
        py_adv   = py_reg;
        adv_last = 1'b1;
        case (cmd_reg)
            pfde_pkg::CMD_HRUN: begin
                px_adv   = px_reg + 9'd1;
                adv_last = (px_reg + 9'd1) == {1'b0, xe_reg};
            end
            pfde_pkg::CMD_VRUN: begin
                py_adv   = py_reg + 9'd1;
                adv_last = (py_reg + 9'd1) == {1'b0, ye_reg};
            end
            pfde_pkg::CMD_LINE: begin
                px_adv   = {1'b0, xneg_reg ? x0_reg - ox_adv : x0_reg + ox_adv};
                py_adv   = {1'b0, yneg_reg ? y0_reg - oy_adv : y0_reg + oy_adv};
                adv_last = (i_reg + 8'd1) == n_reg;
            end
            pfde_pkg::CMD_GLYPH: begin
                px_adv   = {1'b0, x0_reg} + {6'd0, gc_adv};
                py_adv   = {1'b0, y0_reg} + {6'd0, gr_adv};
                adv_last = (gc_reg == 3'(pfde_pkg::GLYPH_W - 1)) &&
                           (gr_reg == 3'(pfde_pkg::GLYPH_H - 1));
            end
            default: adv_last = 1'b1;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfde_pkg::ST_FILL: begin
                if (fill_reg == fend_reg) begin
                    state_next = report_reg ? pfde_pkg::ST_DONE : pfde_pkg::ST_IDLE;
                end
            end
            pfde_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_cmd_e)
                        pfde_pkg::CMD_SET, pfde_pkg::CMD_CLEAR:
                            state_next = pfde_pkg::ST_PIX_RD;
                        pfde_pkg::CMD_HRUN:
                            state_next = (s_x_second > s_x_first) ? pfde_pkg::ST_PIX_RD
                                                                  : pfde_pkg::ST_DONE;
                        pfde_pkg::CMD_VRUN:
                            state_next = (s_y_second > s_y_first) ? pfde_pkg::ST_PIX_RD
                                                                  : pfde_pkg::ST_DONE;
                        pfde_pkg::CMD_LINE:
                            state_next = (s_n != 8'd0) ? pfde_pkg::ST_PIX_RD
                                                       : pfde_pkg::ST_DONE;
                        pfde_pkg::CMD_GLYPH:
                            state_next = (s_item < 8'(pfde_pkg::GLYPH_COUNT))
                                         ? pfde_pkg::ST_PIX_RD : pfde_pkg::ST_DONE;
                        pfde_pkg::CMD_ERASE_PAGE:
                            state_next = s_page_ok ? pfde_pkg::ST_FILL : pfde_pkg::ST_DONE;
                        pfde_pkg::CMD_ERASE_ALL:
                            state_next = pfde_pkg::ST_FILL;
                        pfde_pkg::CMD_READ:
                            state_next = (s_page_ok &&
                                          s_x_first < 8'(pfde_pkg::PANEL_WIDTH))
                                         ? pfde_pkg::ST_RD_REQ : pfde_pkg::ST_DONE;
                        default: state_next = pfde_pkg::ST_DONE;
                    endcase
                end
            end
            pfde_pkg::ST_PIX_RD: begin
                if (in_panel) begin
                    state_next = pfde_pkg::ST_PIX_WR;
                end else if (adv_last) begin
                    state_next = pfde_pkg::ST_DONE;
                end
            end
            pfde_pkg::ST_PIX_WR:
                state_next = adv_last ? pfde_pkg::ST_DONE : pfde_pkg::ST_PIX_RD;
            pfde_pkg::ST_RD_REQ:  state_next = pfde_pkg::ST_RD_WAIT;
            pfde_pkg::ST_RD_WAIT: state_next = pfde_pkg::ST_DONE;
            pfde_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pfde_pkg::ST_IDLE;
                end
            end
            default: state_next = pfde_pkg::ST_IDLE;
        endcase
    end

    // Outputs toward the memory and the request port.
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = pix_addr;
        mem_wdata = 8'd0;
        case (state_reg)
            pfde_pkg::ST_IDLE: s_ready = 1'b1;
            pfde_pkg::ST_FILL: begin
                mem_we   = 1'b1;
                mem_addr = fill_reg;
            end
            pfde_pkg::ST_PIX_WR: begin
                mem_we    = 1'b1;
                mem_wdata = pix_on ? (mem_q_reg | bit_mask) : (mem_q_reg & ~bit_mask);
            end
            pfde_pkg::ST_RD_REQ:
                mem_addr = pfde_pkg::page_addr(y0_reg[pfde_pkg::PAGE_W-1:0], x0_reg);
            default: mem_addr = pix_addr;
        endcase
    end

    // Datapath next values.
    always_comb begin
        cmd_next = cmd_reg;   x0_next = x0_reg;   y0_next = y0_reg;
        xe_next = xe_reg;     ye_next = ye_reg;   px_next = px_reg;
        py_next = py_reg;     ox_next = ox_reg;   oy_next = oy_reg;
        rx_next = rx_reg;     ry_next = ry_reg;   dx_next = dx_reg;
        dy_next = dy_reg;     n_next = n_reg;     i_next = i_reg;
        xneg_next = xneg_reg; yneg_next = yneg_reg; inv_next = inv_reg;
        item_next = item_reg; gc_next = gc_reg;   gr_next = gr_reg;
        fill_next = fill_reg; fend_next = fend_reg; report_next = report_reg;
        rd_next = rd_reg;     ign_next = ign_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rd_next = m_rd_reg; m_ign_next = m_ign_reg;

        if (accept) begin
            cmd_next  = s_cmd_e;
            x0_next   = s_x_first;   y0_next = s_y_first;
            xe_next   = s_x_second;  ye_next = s_y_second;
            px_next   = {1'b0, s_x_first};
            py_next   = {1'b0, s_y_first};
            ox_next   = 8'd0; oy_next = 8'd0; rx_next = 8'd0; ry_next = 8'd0;
            dx_next   = s_dx; dy_next = s_dy; n_next = s_n; i_next = 8'd0;
            xneg_next = s_xneg; yneg_next = s_yneg;
            inv_next  = !s_normal_ink;
            item_next = s_item[6:0];
            gc_next   = 3'd0; gr_next = 3'd0;
            rd_next   = 8'd0;
            report_next = 1'b1;
            if (s_cmd_e == pfde_pkg::CMD_ERASE_ALL) begin
                fill_next = '0;
                fend_next = LAST_ADDR;
            end else begin
                fill_next = page_base;
                fend_next = page_base + pfde_pkg::ADDR_W'(pfde_pkg::PANEL_WIDTH - 1);
            end
            case (s_cmd_e)
                pfde_pkg::CMD_GLYPH:
                    ign_next = !(s_item < 8'(pfde_pkg::GLYPH_COUNT));
                pfde_pkg::CMD_ERASE_PAGE, pfde_pkg::CMD_READ:
                    ign_next = !s_page_ok;
                default: ign_next = 1'b0;
            endcase
        end

        if (state_reg == pfde_pkg::ST_FILL) begin
            fill_next = fill_reg + 1'b1;
        end

        if (advance) begin
            px_next = px_adv;  py_next = py_adv;
            ox_next = ox_adv;  oy_next = oy_adv;
            rx_next = rx_adv;  ry_next = ry_adv;
            i_next  = i_reg + 8'd1;
            gc_next = gc_adv;  gr_next = gr_adv;
        end

        if (state_reg == pfde_pkg::ST_RD_WAIT) begin
            rd_next = mem_q_reg;
        end

        if ((state_reg == pfde_pkg::ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
            m_rd_next    = rd_reg;
            m_ign_next   = ign_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q_reg  <= mem[mem_addr];
        font_q_reg <= pfde_pkg::FONT_ROM[font_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfde_pkg::ST_FILL;
            fill_reg    <= '0;
            fend_reg    <= LAST_ADDR;
            report_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            fend_reg    <= fend_next;
            report_reg  <= report_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;   x0_reg <= x0_next;   y0_reg <= y0_next;
        xe_reg <= xe_next;     ye_reg <= ye_next;   px_reg <= px_next;
        py_reg <= py_next;     ox_reg <= ox_next;   oy_reg <= oy_next;
        rx_reg <= rx_next;     ry_reg <= ry_next;   dx_reg <= dx_next;
        dy_reg <= dy_next;     n_reg <= n_next;     i_reg <= i_next;
        xneg_reg <= xneg_next; yneg_reg <= yneg_next; inv_reg <= inv_next;
        item_reg <= item_next; gc_reg <= gc_next;   gr_reg <= gr_next;
        rd_reg <= rd_next;     ign_reg <= ign_next;
        m_rd_reg <= m_rd_next; m_ign_reg <= m_ign_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_rd_reg;
    assign m_ignored   = m_ign_reg;

endmodule
